/* rtl/gma_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// gma_pkg - shared types and constants of the gradient merge accumulator
// Field widths, item classes, queue entry layout and saturation helper.
// ============================================================================
package gma_pkg;

    localparam int NCH = 3;           // channel lanes carried by the ports
    localparam int GW  = 16;          // gradient and mask width, Q1.15
    localparam int SW  = 32;          // sum width
    localparam int CW  = 24;          // count width, Q9.15
    localparam int WW  = 15;          // blend weight width
    localparam int DVW = 47;          // readout dividend: |sum| * 2^15 + count/2

    localparam logic [CW-1:0] COUNT_MAX = 24'hFF_FFFF;
    localparam logic [CW-1:0] COUNT_ONE = 24'd32768;
    localparam logic [GW-1:0] ONE_Q15   = 16'h8000;
    localparam logic signed [48:0] HALF_LSB = 49'sd16384;
    localparam logic signed [48:0] SAT_HI   = 49'sd2147483647;
    localparam logic signed [48:0] SAT_LO   = -49'sd2147483648;

    typedef enum logic [0:0] {
        OP_ACC  = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        MODE_OVERLAY = 1'b0,
        MODE_AVERAGE = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        CLS_READ      = 3'd0,
        CLS_READ_NULL = 3'd1,
        CLS_AVERAGE   = 3'd2,
        CLS_OVERLAY   = 3'd3,
        CLS_BORDER    = 3'd4
    } cls_t;

    typedef struct packed {
        cls_t                  cls;
        logic [15:0]           address;
        logic [NCH-1:0][GW-1:0] grad;
        logic [WW-1:0]         weight;
    } qitem_t;

    function automatic logic [SW-1:0] sat32(input logic signed [48:0] v);
        logic [SW-1:0] r;
        if (v > SAT_HI)
            r = 32'h7FFF_FFFF;
        else if (v < SAT_LO)
            r = 32'h8000_0000;
        else
            r = v[SW-1:0];
        return r;
    endfunction

endpackage

/* rtl/gma_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// gma_if - request channels of the gradient merge accumulator
// Sample, result and configuration channels with valid/ready handshake.
// ============================================================================
interface gma_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [15:0]        address;
    logic signed [15:0] grad_0;
    logic signed [15:0] grad_1;
    logic signed [15:0] grad_2;
    logic signed [15:0] mask_a;
    logic signed [15:0] mask_b;

    modport source (output valid, op, address, grad_0, grad_1, grad_2, mask_a, mask_b,
                    input ready);
    modport sink   (input valid, op, address, grad_0, grad_1, grad_2, mask_a, mask_b,
                    output ready);
endinterface

interface gma_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        out_address;
    logic signed [31:0] value_0;
    logic signed [31:0] value_1;
    logic signed [31:0] value_2;
    logic [23:0]        weight_total;

    modport source (output valid, out_address, value_0, value_1, value_2, weight_total,
                    input ready);
    modport sink   (input valid, out_address, value_0, value_1, value_2, weight_total,
                    output ready);
endinterface

interface gma_cfg_if;
    logic valid;
    logic ready;
    logic merge_mode;

    modport source (output valid, merge_mode, input ready);
    modport sink   (input valid, merge_mode, output ready);
endinterface

/* rtl/gma_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// gma_front - request intake and classification
// Range check, mean mask weight and item class; drops no-op requests.
// ============================================================================
module gma_front #(
    parameter int STORE_DEPTH = 65536
) (
    gma_in_if.sink          sample,
    input  gma_pkg::mode_t  mode,
    input  logic            allow,
    input  logic            push_ready,
    output logic            push_valid,
    output gma_pkg::qitem_t push_item
);
    import gma_pkg::*;

    logic        in_range;
    logic        a_pos, b_pos, a_neg, b_neg;
    logic [16:0] wsum;
    logic        keep;
    cls_t        cls;

    assign in_range = ({17'd0, sample.address} < 33'(STORE_DEPTH));
    assign a_neg    = sample.mask_a[15];
    assign b_neg    = sample.mask_b[15];
    assign a_pos    = !a_neg && (sample.mask_a != '0);
    assign b_pos    = !b_neg && (sample.mask_b != '0);
    assign wsum     = {1'b0, sample.mask_a} + {1'b0, sample.mask_b};

    always_comb
    begin
        keep = 1'b1;
        cls  = CLS_READ;
        if (op_t'(sample.op) == OP_READ)
        begin
            cls = in_range ? CLS_READ : CLS_READ_NULL;
        end
        else if (!in_range)
        begin
            keep = 1'b0;
        end
        else if (a_pos && b_pos)
        begin
            cls = (mode == MODE_AVERAGE) ? CLS_AVERAGE : CLS_OVERLAY;
        end
        else if (a_neg || b_neg)
        begin
            cls = CLS_BORDER;
        end
        else
        begin
            keep = 1'b0;    // background: nothing to do
        end
    end

    assign sample.ready = allow && push_ready;
    assign push_valid   = sample.valid && allow && keep;

    assign push_item.cls     = cls;
    assign push_item.address = sample.address;
    assign push_item.grad[0] = sample.grad_0;
    assign push_item.grad[1] = sample.grad_1;
    assign push_item.grad[2] = sample.grad_2;
    assign push_item.weight  = wsum[WW:1];

endmodule

/* rtl/gma_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// gma_queue - two-entry queue between intake and store engine
// ============================================================================
module gma_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  gma_pkg::qitem_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output gma_pkg::qitem_t pop_item
);
    import gma_pkg::*;

    qitem_t      slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 2'd1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* rtl/gma_div.sv */
`timescale 1ns / 1ps
// ============================================================================
// gma_div - three-lane restoring divider, one quotient bit per cycle
// Shared divisor; done follows the last quotient bit.
// ============================================================================
module gma_div (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic [gma_pkg::NCH-1:0][gma_pkg::DVW-1:0] dividend,
    input  logic [gma_pkg::CW-1:0]                  divisor,
    output logic                                    done,
    output logic [gma_pkg::NCH-1:0][gma_pkg::DVW-1:0] quotient
);
    import gma_pkg::*;

    localparam int STW = $clog2(DVW);

    logic [STW-1:0]             step_reg;
    logic                       run_reg;
    logic                       done_reg;
    logic [NCH-1:0][DVW-1:0]    quo_reg, quo_next;
    logic [NCH-1:0][CW-1:0]     rem_reg, rem_next;
    logic [CW-1:0]              dsr_reg;

    always_comb
    begin
        logic [CW:0] trial;
        logic [CW:0] diff;
        for (int c = 0; c < NCH; c++)
        begin
            trial = {rem_reg[c], quo_reg[c][DVW-1]};
            diff  = trial - {1'b0, dsr_reg};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next[c] = diff[CW-1:0];
                quo_next[c] = {quo_reg[c][DVW-2:0], 1'b1};
            end
            else
            begin
                rem_next[c] = trial[CW-1:0];
                quo_next[c] = {quo_reg[c][DVW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= STW'(DVW - 1);
            end
            else if (run_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/gma_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// gma_back - store engine: clearing pass, read-modify-write, readout
// Holds the sum and count stores, blend arithmetic and the result register.
// ============================================================================
module gma_back #(
    parameter int STORE_DEPTH = 65536,
    parameter int CHANNELS    = 3
) (
    input  logic            clk,
    input  logic            rst_n,
    input  gma_pkg::mode_t  mode,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  gma_pkg::qitem_t pop_item,
    output logic            clear_done,
    gma_out_if.source       result
);
    import gma_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b000_0001,
        S_IDLE  = 7'b000_0010,
        S_READ  = 7'b000_0100,
        S_MUL   = 7'b000_1000,
        S_WRITE = 7'b001_0000,
        S_DIV   = 7'b010_0000,
        S_OUT   = 7'b100_0000
    } state_t;

    state_t                     state_reg, state_next;
    logic [AW-1:0]              clr_idx_reg;
    qitem_t                     item_reg;
    logic [AW+15:0]             addr_ext;
    logic [AW-1:0]              idx;
    logic [AW-1:0]              wr_idx;
    logic                       mem_we;
    logic [SW-1:0]              wr_sum [NCH];
    logic [CW-1:0]              wr_cnt;
    logic [SW-1:0]              rd_sum_reg [NCH];
    logic [CW-1:0]              rd_cnt_reg;
    logic signed [31:0]         pg_reg [NCH];
    logic signed [48:0]         ps_reg [NCH];
    logic [SW-1:0]              new_sum [NCH];
    logic [CW-1:0]              new_cnt;
    logic                       cnt_zero;
    logic                       is_read;
    logic                       need_div;
    logic                       div_start;
    logic                       div_done;
    logic [NCH-1:0][DVW-1:0]    div_dvd;
    logic [NCH-1:0][DVW-1:0]    div_quo;
    logic [NCH-1:0]             neg_reg;
    logic [SW-1:0]              out_val_reg [NCH];
    logic [15:0]                out_addr_reg;
    logic [CW-1:0]              out_wt_reg;
    logic [SW-1:0]              div_val [NCH];

    assign addr_ext = {{AW{1'b0}}, item_reg.address};
    assign idx      = addr_ext[AW-1:0];
    assign cnt_zero = (rd_cnt_reg == '0);
    assign is_read  = (item_reg.cls == CLS_READ) || (item_reg.cls == CLS_READ_NULL);
    assign need_div = (item_reg.cls == CLS_READ) && (mode == MODE_AVERAGE) && !cnt_zero;
    assign div_start = (state_reg == S_MUL) && need_div;

    // ---------------- stores ----------------
    assign mem_we = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
    assign wr_idx = (state_reg == S_CLEAR) ? clr_idx_reg : idx;
    assign wr_cnt = (state_reg == S_CLEAR) ? '0 : new_cnt;

    for (genvar c = 0; c < NCH; c++)
    begin : g_lane
        assign wr_sum[c] = (state_reg == S_CLEAR) ? '0 : new_sum[c];
        if (c < CHANNELS)
        begin : g_mem
            logic [SW-1:0] sum_mem [STORE_DEPTH];
            always_ff @(posedge clk)
            begin
                if (mem_we)
                    sum_mem[wr_idx] <= wr_sum[c];
                rd_sum_reg[c] <= sum_mem[idx];
            end
        end
        else
        begin : g_none
            always_ff @(posedge clk)
            begin
                rd_sum_reg[c] <= '0;
            end
        end
    end

    logic [CW-1:0] cnt_mem [STORE_DEPTH];
    always_ff @(posedge clk)
    begin
        if (mem_we)
            cnt_mem[wr_idx] <= wr_cnt;
        rd_cnt_reg <= cnt_mem[idx];
    end

    // ---------------- products ----------------
    always_ff @(posedge clk)
    begin
        logic [GW-1:0] inv_w;
        inv_w = ONE_Q15 - {1'b0, item_reg.weight};
        for (int c = 0; c < NCH; c++)
        begin
            pg_reg[c] <= $signed(item_reg.grad[c]) * $signed({1'b0, item_reg.weight});
            ps_reg[c] <= $signed(rd_sum_reg[c]) * $signed({1'b0, inv_w});
        end
    end

    // ---------------- blend ----------------
    always_comb
    begin
        logic signed [48:0] g49;
        logic signed [48:0] s49;
        logic signed [48:0] p49;
        logic signed [48:0] acc;
        logic [CW:0]        csum;
        for (int c = 0; c < NCH; c++)
        begin
            g49 = 49'($signed(item_reg.grad[c]));
            s49 = 49'($signed(rd_sum_reg[c]));
            p49 = (49'(pg_reg[c]) + HALF_LSB) >>> 15;
            acc = (49'(pg_reg[c]) + ps_reg[c] + HALF_LSB) >>> 15;
            case (item_reg.cls)
                CLS_AVERAGE: new_sum[c] = sat32(cnt_zero ? p49 : s49 + p49);
                CLS_OVERLAY: new_sum[c] = cnt_zero ? g49[SW-1:0] : sat32(acc);
                CLS_BORDER:  new_sum[c] = cnt_zero ? g49[SW-1:0] : rd_sum_reg[c];
                default:     new_sum[c] = rd_sum_reg[c];
            endcase
        end
        csum = {1'b0, rd_cnt_reg} + {{(CW+1-WW){1'b0}}, item_reg.weight};
        case (item_reg.cls)
            CLS_AVERAGE: new_cnt = csum[CW] ? COUNT_MAX : csum[CW-1:0];
            CLS_OVERLAY: new_cnt = cnt_zero ? COUNT_ONE : rd_cnt_reg;
            default:     new_cnt = rd_cnt_reg;
        endcase
    end

    // ---------------- readout division ----------------
    always_comb
    begin
        logic [SW-1:0] mag;
        for (int c = 0; c < NCH; c++)
        begin
            mag = rd_sum_reg[c][SW-1] ? (~rd_sum_reg[c] + 1'b1) : rd_sum_reg[c];
            div_dvd[c] = {mag, 15'd0} + {{(DVW-CW+1){1'b0}}, rd_cnt_reg[CW-1:1]};
            if (neg_reg[c])
                div_val[c] = (div_quo[c] > 47'h0_8000_0000) ? 32'h8000_0000
                                                             : (~div_quo[c][SW-1:0] + 1'b1);
            else
                div_val[c] = (div_quo[c] > 47'h0_7FFF_FFFF) ? 32'h7FFF_FFFF
                                                             : div_quo[c][SW-1:0];
        end
    end

    gma_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (rd_cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_idx_reg == AW'(STORE_DEPTH - 1)) state_next = S_IDLE;
            S_IDLE:  if (pop_valid) state_next = S_READ;
            S_READ:  state_next = S_MUL;
            S_MUL:
            begin
                if (!is_read)
                    state_next = S_WRITE;
                else if (need_div)
                    state_next = S_DIV;
                else
                    state_next = S_OUT;
            end
            S_WRITE: state_next = S_IDLE;
            S_DIV:   if (div_done) state_next = S_OUT;
            S_OUT:   if (result.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && pop_valid)
            item_reg <= pop_item;
        if (div_start)
            for (int c = 0; c < NCH; c++)
                neg_reg[c] <= rd_sum_reg[c][SW-1];
        if (state_reg == S_MUL && is_read && !need_div)
        begin
            out_addr_reg <= item_reg.address;
            out_wt_reg   <= (item_reg.cls == CLS_READ_NULL) ? '0 : rd_cnt_reg;
            for (int c = 0; c < NCH; c++)
                out_val_reg[c] <= (item_reg.cls == CLS_READ_NULL) ? '0 : rd_sum_reg[c];
        end
        else if (state_reg == S_DIV && div_done)
        begin
            out_addr_reg <= item_reg.address;
            out_wt_reg   <= rd_cnt_reg;
            for (int c = 0; c < NCH; c++)
                out_val_reg[c] <= div_val[c];
        end
    end

    assign pop_ready  = (state_reg == S_IDLE);
    assign clear_done = (state_reg != S_CLEAR);

    assign result.valid        = (state_reg == S_OUT);
    assign result.out_address  = out_addr_reg;
    assign result.value_0      = out_val_reg[0];
    assign result.value_1      = out_val_reg[1];
    assign result.value_2      = out_val_reg[2];
    assign result.weight_total = out_wt_reg;

endmodule

/* rtl/gradient_merge_accumulator.sv */
`timescale 1ns / 1ps
// ============================================================================
// gradient_merge_accumulator - weighted blend accumulator for gradients
// Gathers Q1.15 gradient requests into per-entry sums and counts, and reads
// entries back either raw (overlay) or normalised by the count (average).
// ============================================================================
// Usage:
//   sample : accumulate (op 0) or readout (op 1) requests, valid/ready.
//   result : one request per readout; accumulates return nothing.
//   cfg    : merge_mode write, always ready; change it only while idle.
// Reset: after rst_n rises the stores are swept to zero, one entry per
//   cycle, all STORE_DEPTH entries; sample.ready stays low until the sweep ends.
// Timing: the store engine handles one request at a time.
//   accumulate      take, store read, multiply, write back
//   overlay readout take, store read, result register, then result.valid
//   average readout take, store read, 47-step bit-serial divide, result register
//   background or out-of-range accumulates are dropped at intake.
// A two-entry queue sits between intake and store engine, so requests keep
// being taken while a result waits; a stalled result.ready holds the engine
// and, once the queue is full, lowers sample.ready.
// ============================================================================
module gradient_merge_accumulator #(
    parameter int STORE_DEPTH = 65536,
    parameter int CHANNELS    = 3
) (
    input  logic      clk,
    input  logic      rst_n,
    gma_in_if.sink    sample,
    gma_out_if.source result,
    gma_cfg_if.sink   cfg
);
    import gma_pkg::*;

    mode_t  mode_reg;
    logic   push_valid, push_ready;
    qitem_t push_item;
    logic   pop_valid, pop_ready;
    qitem_t pop_item;
    logic   clear_done;

    // mode register; writes are taken every cycle, including during the sweep
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_OVERLAY;
        else if (cfg.valid)
            mode_reg <= mode_t'(cfg.merge_mode);
    end

    // intake: range check, weight and classification
    gma_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .sample     (sample),
        .mode       (mode_reg),
        .allow      (clear_done),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    // decoupling queue
    gma_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // store engine with result register
    gma_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .CHANNELS    (CHANNELS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .clear_done (clear_done),
        .result     (result)
    );

endmodule

/* rtl/gma_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// gma_checker - port-level checks on the gradient merge accumulator
// ============================================================================
module gma_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [15:0] res_address,
    input logic [31:0] res_value_0,
    input logic [23:0] res_weight,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_address) && $stable(res_value_0)
                                    && $stable(res_weight))
        else $error("result changed while stalled");

    a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_ready)
        else $error("request taken during store sweep");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("mode write refused");

endmodule

bind gradient_merge_accumulator gma_checker u_gma_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (sample.ready),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_address (result.out_address),
    .res_value_0 (result.value_0),
    .res_weight  (result.weight_total),
    .cfg_valid   (cfg.valid),
    .cfg_ready   (cfg.ready)
);

/* verif/gradient_merge_accumulator_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// gradient_merge_accumulator_tb - self-checking bench for the merge accumulator
// Drives accumulate and readout requests with random gaps and result stalls.
// A local model of the stores predicts every readout, which is checked field
// by field. It runs several merge_mode phases, including a count saturation burst.
// ============================================================================
module gradient_merge_accumulator_tb;
    import gma_pkg::*;

    // one pending sample request
    typedef struct {
        op_t                op;
        logic [15:0]        address;
        logic signed [15:0] grad [3];
        logic signed [15:0] mask_a;
        logic signed [15:0] mask_b;
    } sample_req_t;

    // one predicted readout
    typedef struct {
        logic [15:0]        address;
        logic signed [31:0] value [3];
        logic [23:0]        weight;
    } readout_t;

    // modelled store entry; entries never touched read back as zero
    typedef struct {
        logic signed [31:0] sum [3];
        logic [23:0]        count;
    } entry_t;

    logic clk;
    logic rst_n;
    bit   failed;
    bit   quiet;          // no idling on either side while set
    mode_t blend_mode;    // mode the model follows

    sample_req_t pending_reqs [$];
    readout_t    expected_readouts [$];
    entry_t      store_model [int];

    gma_in_if  smp ();
    gma_out_if res ();
    gma_cfg_if cfg_ch ();

    gradient_merge_accumulator DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp),
        .result (res),
        .cfg    (cfg_ch)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Q.30 back to Q.15, rounding half up
    function automatic longint round_q15(input longint v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    // Applies one accepted request to the store model; a read queues a readout.
    function automatic void merge_request(input sample_req_t r);
        entry_t   e;
        readout_t o;
        longint   a, b, w, g, s, p, mag, q;
        longint unsigned nc;
        if (store_model.exists(r.address))
            e = store_model[r.address];
        else
        begin
            e.sum   = '{0, 0, 0};
            e.count = '0;
        end
        if (r.op == OP_READ)
        begin
            o.address = r.address;
            o.weight  = e.count;
            for (int c = 0; c < 3; c++)
            begin
                s = e.sum[c];
                if (blend_mode == MODE_AVERAGE && e.count != 0)
                begin
                    mag = (s < 0 ? -s : s) * 32768;
                    q   = (mag + e.count / 2) / e.count;
                    s   = clamp32(s < 0 ? -q : q);
                end
                o.value[c] = s[31:0];
            end
            expected_readouts.push_back(o);
            return;
        end
        a = r.mask_a;
        b = r.mask_b;
        if (a > 0 && b > 0)
        begin
            w = (a + b) / 2;
            if (blend_mode == MODE_AVERAGE)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    g = r.grad[c];
                    p = round_q15(g * w);
                    e.sum[c] = clamp32(e.count == 0 ? p : longint'(e.sum[c]) + p);
                end
                nc = e.count + w;
                e.count = nc > 64'hFF_FFFF ? 24'hFF_FFFF : nc[23:0];
            end
            else if (e.count == 0)
            begin
                for (int c = 0; c < 3; c++)
                    e.sum[c] = r.grad[c];
                e.count = 24'd32768;
            end
            else
            begin
                // blend: g*w + sum*(1.0 - w)
                for (int c = 0; c < 3; c++)
                begin
                    g = r.grad[c];
                    s = e.sum[c];
                    e.sum[c] = clamp32(round_q15(g * w + s * (32768 - w)));
                end
            end
        end
        else if (e.count == 0 && (a < 0 || b < 0))
        begin
            // border pixel on an empty entry: raw copy, count untouched
            for (int c = 0; c < 3; c++)
                e.sum[c] = r.grad[c];
        end
        store_model[r.address] = e;
    endfunction

    task automatic queue_req(input op_t op, input logic [15:0] addr,
                             input logic [15:0] g0, input logic [15:0] g1,
                             input logic [15:0] g2, input logic [15:0] ma,
                             input logic [15:0] mb);
        sample_req_t r;
        r.op      = op;
        r.address = addr;
        r.grad    = '{g0, g1, g2};
        r.mask_a  = ma;
        r.mask_b  = mb;
        pending_reqs.push_back(r);
    endtask

    // Random request biased towards a small set of entries so that hits stack up.
    task automatic queue_random(input int n);
        logic [15:0] ma, mb, addr;
        int          k;
        for (int i = 0; i < n; i++)
        begin
            addr = ($urandom_range(99) < 75) ? 16'(100 + $urandom_range(7))
                                             : 16'($urandom);
            k = $urandom_range(99);
            if (k < 60)
            begin
                ma = 16'($urandom_range(32767, 1));
                mb = 16'($urandom_range(32767, 1));
            end
            else if (k < 75)
            begin
                ma = 16'($urandom_range(32767, 1)) | 16'h8000;
                mb = 16'($urandom);
            end
            else if (k < 85)
            begin
                ma = '0;
                mb = 16'($urandom);
            end
            else
            begin
                ma = 16'($urandom);
                mb = 16'($urandom);
            end
            queue_req(($urandom_range(99) < 25) ? OP_READ : OP_ACC, addr,
                      16'($urandom), 16'($urandom), 16'($urandom), ma, mb);
        end
    endtask

    // Wait until every request is taken and every readout has arrived, then
    // allow for a dropped or still running accumulate.
    task automatic drain();
        while (pending_reqs.size() != 0 || smp.valid || expected_readouts.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_mode(input mode_t m);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.merge_mode <= m;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        blend_mode = m;
        cfg_ch.valid <= 1'b0;
    endtask

    // Request driver: model update on acceptance, then next request or a gap.
    always @(posedge clk)
    begin
        sample_req_t r;
        if (smp.valid && smp.ready)
        begin
            r.op      = op_t'(smp.op);
            r.address = smp.address;
            r.grad    = '{smp.grad_0, smp.grad_1, smp.grad_2};
            r.mask_a  = smp.mask_a;
            r.mask_b  = smp.mask_b;
            merge_request(r);
        end
        if ((!smp.valid || smp.ready) && rst_n)
        begin
            if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= 14))
            begin
                r = pending_reqs.pop_front();
                smp.valid   <= 1'b1;
                smp.op      <= r.op;
                smp.address <= r.address;
                smp.grad_0  <= r.grad[0];
                smp.grad_1  <= r.grad[1];
                smp.grad_2  <= r.grad[2];
                smp.mask_a  <= r.mask_a;
                smp.mask_b  <= r.mask_b;
            end
            else
                smp.valid <= 1'b0;
        end
    end

    // Result side: random stalls, and a check of each readout against the model.
    always @(posedge clk)
    begin
        readout_t o;
        res.ready <= quiet || ($urandom_range(99) >= 14);
        if (res.valid && res.ready)
        begin
            if (expected_readouts.size() == 0)
            begin
                $display("%0t: unexpected readout, expected none, actual address %0d",
                         $time, res.out_address);
                failed = 1'b1;
            end
            else
            begin
                o = expected_readouts.pop_front();
                if (res.out_address !== o.address)
                begin
                    $display("%0t: out_address expected %0d actual %0d",
                             $time, o.address, res.out_address);
                    failed = 1'b1;
                end
                if (res.value_0 !== o.value[0])
                begin
                    $display("%0t: value_0 expected %0d actual %0d",
                             $time, o.value[0], res.value_0);
                    failed = 1'b1;
                end
                if (res.value_1 !== o.value[1])
                begin
                    $display("%0t: value_1 expected %0d actual %0d",
                             $time, o.value[1], res.value_1);
                    failed = 1'b1;
                end
                if (res.value_2 !== o.value[2])
                begin
                    $display("%0t: value_2 expected %0d actual %0d",
                             $time, o.value[2], res.value_2);
                    failed = 1'b1;
                end
                if (res.weight_total !== o.weight)
                begin
                    $display("%0t: weight_total expected %0d actual %0d",
                             $time, o.weight, res.weight_total);
                    failed = 1'b1;
                end
            end
        end
    end

    // Timeout: covers the reset sweep, the saturation burst and all stalls.
    initial
    begin
        #6_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        failed     = 1'b0;
        quiet      = 1'b0;
        blend_mode = MODE_OVERLAY;
        rst_n      = 1'b0;
        smp.valid  = 1'b0;
        smp.op     = 1'b0;
        smp.address = '0;
        smp.grad_0 = '0;
        smp.grad_1 = '0;
        smp.grad_2 = '0;
        smp.mask_a = '0;
        smp.mask_b = '0;
        res.ready  = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.merge_mode = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_mode(MODE_OVERLAY);

        // Overlay: first hit copies, later hits blend, border and background.
        queue_req(OP_READ, 16'd0,     '0, '0, '0, '0, '0);   // untouched entry
        queue_req(OP_ACC,  16'd0,     16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 16'h7FFF);
        queue_req(OP_ACC,  16'd0,     16'h8000, 16'h7FFF, 16'h1234, 16'h0001, 16'h0001);
        queue_req(OP_ACC,  16'd0,     16'h0100, 16'hFF00, 16'h7FFF, 16'h7FFF, 16'h0001);
        queue_req(OP_READ, 16'd0,     '0, '0, '0, '0, '0);
        queue_req(OP_ACC,  16'hFFFF,  16'h4000, 16'hC000, 16'h0001, 16'h8000, 16'h0010);
        queue_req(OP_READ, 16'hFFFF,  '0, '0, '0, '0, '0);   // border copy
        queue_req(OP_ACC,  16'hFFFF,  16'h1111, 16'h2222, 16'h3333, 16'h0000, 16'h7FFF);
        queue_req(OP_ACC,  16'hFFFF,  16'h1111, 16'h2222, 16'h3333, 16'h0040, 16'hFFFF);
        queue_req(OP_READ, 16'hFFFF,  '0, '0, '0, '0, '0);   // background, border on count 0
        queue_req(OP_ACC,  16'd0,     16'h5555, 16'h5555, 16'h5555, 16'hFFFF, 16'h0100);
        queue_req(OP_READ, 16'd0,     '0, '0, '0, '0, '0);   // border on live entry ignored
        drain();

        set_mode(MODE_AVERAGE);
        queue_req(OP_ACC,  16'd1,     16'h7FFF, 16'h8000, 16'hAAAA, 16'h7FFF, 16'h7FFF);
        queue_req(OP_ACC,  16'd1,     16'h8000, 16'h0001, 16'h5555, 16'h0001, 16'h0002);
        queue_req(OP_READ, 16'd1,     '0, '0, '0, '0, '0);
        queue_req(OP_READ, 16'd2,     '0, '0, '0, '0, '0);   // zero count
        queue_req(OP_READ, 16'd0,     '0, '0, '0, '0, '0);   // overlay entry averaged
        queue_req(OP_READ, 16'hFFFF,  '0, '0, '0, '0, '0);   // zero count, raw sum
        drain();

        // Random phases, alternating mode; the second one has no idling at all.
        for (int ph = 0; ph < 4; ph++)
        begin
            set_mode(ph[0] ? MODE_OVERLAY : MODE_AVERAGE);
            quiet = (ph == 1);
            queue_random(95);
            drain();
        end
        quiet = 1'b0;

        // Saturation burst: the count of one entry runs into its limit.
        set_mode(MODE_AVERAGE);
        for (int i = 0; i < 520; i++)
        begin
            queue_req(OP_ACC, 16'd7, 16'h7FFF, 16'h8000, 16'($urandom), 16'h7FFF, 16'h7FFF);
            if (i % 100 == 0)
                queue_req(OP_READ, 16'd7, '0, '0, '0, '0, '0);
        end
        queue_req(OP_READ, 16'd7, '0, '0, '0, '0, '0);
        drain();
        set_mode(MODE_OVERLAY);
        queue_req(OP_ACC,  16'd7, 16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'h0001);
        queue_req(OP_READ, 16'd7, '0, '0, '0, '0, '0);
        drain();

        if (!failed)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/gma_pkg.sv
rtl/gma_if.sv
rtl/gma_front.sv
rtl/gma_queue.sv
rtl/gma_div.sv
rtl/gma_back.sv
rtl/gradient_merge_accumulator.sv
rtl/gma_checker.sv
verif/gradient_merge_accumulator_tb.sv
